// ===== design/dwd_pkg.sv =====
// ----------------------------------------------------------------------------
// dwd_pkg: shared types for the deque with delete by value
// Command and status codes, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dwd_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_DUMP_FWD   = 3'd3,
        OP_DUMP_BWD   = 3'd4
    } dwd_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_ELEMENT   = 3'd4
    } dwd_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DUMP_RD,
        S_DUMP_EMIT
    } dwd_state_t;

    // logical index used for the storage read
    typedef enum logic [1:0] {
        RSEL_IDX,
        RSEL_NEXT,
        RSEL_REV
    } dwd_rsel_t;

    // storage write address source
    typedef enum logic [1:0] {
        WSEL_FRONT,
        WSEL_BACK,
        WSEL_MOVE
    } dwd_wsel_t;

    typedef struct packed {
        logic        load;
        logic        mem_we;
        dwd_wsel_t   wsel;
        logic        occ_inc;
        logic        front_dec;
        logic        occ_dec;
        logic        idx_inc;
        logic        rd_en;
        dwd_rsel_t   rsel;
        logic        emit;
        dwd_status_t emit_status;
        logic        emit_elem;
        logic        emit_last;
    } dwd_ctl_t;

    typedef struct packed {
        dwd_op_t op;
        logic    full;
        logic    empty;
        logic    match;
        logic    idx_last;
        logic    idx_next_last;
        logic    out_free;
    } dwd_sts_t;

endpackage

// ===== design/dwd_in_if.sv =====
// ----------------------------------------------------------------------------
// dwd_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface dwd_in_if;
    import dwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

// ===== design/dwd_out_if.sv =====
// ----------------------------------------------------------------------------
// dwd_out_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dwd_out_if;
    import dwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    modport source (output valid, output status, output element, output last, input ready);
    modport sink   (input valid, input status, input element, input last, output ready);

endinterface

// ===== design/dwd_dpath.sv =====
// ----------------------------------------------------------------------------
// dwd_dpath: storage, ring pointers and result register
// Ring storage with one write port and one registered read port, the
// front/occupancy pointers, a logical index counter and the result register.
// ----------------------------------------------------------------------------
module dwd_dpath #(
    parameter int CAPACITY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dwd_pkg::dwd_ctl_t                 ctl,
    output dwd_pkg::dwd_sts_t                 sts,
    input  logic [dwd_pkg::CMD_W-1:0]         in_cmd,
    input  logic signed [dwd_pkg::DATA_W-1:0] in_value,
    output logic                              out_valid,
    output logic [dwd_pkg::STATUS_W-1:0]      out_status,
    output logic signed [dwd_pkg::DATA_W-1:0] out_element,
    output logic                              out_last,
    input  logic                              out_ready
);
    import dwd_pkg::*;

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCCW = $clog2(CAPACITY + 1);
    localparam int SUMW = OCCW + 1;

    // logical position -> ring slot, one compare and subtract
    function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] base,
                                             input logic [OCCW-1:0] lidx);
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(lidx);
        if (sum >= SUMW'(CAPACITY))
        begin
            sum = sum - SUMW'(CAPACITY);
        end
        return sum[IDXW-1:0];
    endfunction

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    logic [IDXW-1:0]   front_reg;
    logic [OCCW-1:0]   occ_reg;
    logic [OCCW-1:0]   idx_reg;
    dwd_op_t           op_reg;
    logic [DATA_W-1:0] val_reg;

    logic                   out_valid_reg;
    dwd_status_t            out_status_reg;
    logic [DATA_W-1:0]      out_element_reg;
    logic                   out_last_reg;

    logic [IDXW-1:0]   front_prev;
    logic [OCCW-1:0]   idx_plus1;
    logic [OCCW-1:0]   idx_rev;
    logic [OCCW-1:0]   rd_lidx;
    logic [IDXW-1:0]   rd_addr;
    logic [IDXW-1:0]   wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              out_free;

    assign front_prev = (front_reg == '0) ? IDXW'(CAPACITY - 1) : front_reg - 1'b1;
    assign idx_plus1  = idx_reg + 1'b1;
    assign idx_rev    = occ_reg - 1'b1 - idx_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (ctl.rsel)
            RSEL_IDX:  rd_lidx = idx_reg;
            RSEL_NEXT: rd_lidx = idx_plus1;
            RSEL_REV:  rd_lidx = idx_rev;
            default:   rd_lidx = idx_reg;
        endcase
        rd_addr = phys(front_reg, rd_lidx);

        case (ctl.wsel)
            WSEL_FRONT:
            begin
                wr_addr = front_prev;
                wr_data = val_reg;
            end
            WSEL_BACK:
            begin
                wr_addr = phys(front_reg, occ_reg);
                wr_data = val_reg;
            end
            WSEL_MOVE:
            begin
                wr_addr = phys(front_reg, idx_reg);
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = phys(front_reg, idx_reg);
                wr_data = rdata_reg;
            end
        endcase
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= dwd_op_t'(in_cmd);
            val_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (ctl.front_dec)
            begin
                front_reg <= front_prev;
            end
            if (ctl.occ_inc)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (ctl.occ_dec)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
            if (ctl.load)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_plus1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_status_reg  <= ctl.emit_status;
            out_element_reg <= ctl.emit_elem ? rdata_reg : '0;
            out_last_reg    <= ctl.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_element = out_element_reg;
    assign out_last    = out_last_reg;

    always_comb
    begin
        sts.op            = op_reg;
        sts.full          = (occ_reg == OCCW'(CAPACITY));
        sts.empty         = (occ_reg == '0);
        sts.match         = (rdata_reg == val_reg);
        sts.idx_last      = ((SUMW'(idx_reg) + SUMW'(1)) == SUMW'(occ_reg));
        sts.idx_next_last = ((SUMW'(idx_reg) + SUMW'(2)) == SUMW'(occ_reg));
        sts.out_free      = out_free;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCCW'(CAPACITY))
        else $error("occupancy above capacity");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.occ_inc |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("push did not grow occupancy by one");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> out_free)
        else $error("result register overwritten");

endmodule

// ===== design/dwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwd_ctrl: command sequencer
// Decodes each item and steps the datapath through push, scan/compact and
// dump sequences, one result at a time into the result register.
// ----------------------------------------------------------------------------
module dwd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output dwd_pkg::dwd_ctl_t ctl,
    input  dwd_pkg::dwd_sts_t sts
);
    import dwd_pkg::*;

    dwd_state_t  state_reg;
    dwd_state_t  state_next;
    dwd_status_t resp_reg;
    dwd_status_t resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        in_ready   = 1'b0;
        ctl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (sts.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        if (sts.full)
                        begin
                            resp_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.mem_we    = 1'b1;
                            ctl.occ_inc   = 1'b1;
                            ctl.front_dec = (sts.op == OP_PUSH_FRONT);
                            ctl.wsel      = (sts.op == OP_PUSH_FRONT) ? WSEL_FRONT
                                                                      : WSEL_BACK;
                            resp_next     = ST_DONE;
                        end
                        state_next = S_RESP;
                    end
                    OP_REMOVE:
                    begin
                        if (sts.empty)
                        begin
                            resp_next  = ST_NOT_FOUND;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_DUMP_FWD, OP_DUMP_BWD:
                    begin
                        if (sts.empty)
                        begin
                            resp_next  = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_DUMP_RD;
                        end
                    end
                    default:
                    begin
                        resp_next  = ST_DONE;
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rsel   = RSEL_IDX;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    if (sts.idx_last)
                    begin
                        ctl.occ_dec = 1'b1;
                        resp_next   = ST_DONE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MOVE_RD;
                    end
                end
                else if (sts.idx_last)
                begin
                    resp_next  = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end

            S_MOVE_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rsel   = RSEL_NEXT;
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                ctl.mem_we  = 1'b1;
                ctl.wsel    = WSEL_MOVE;
                ctl.idx_inc = 1'b1;
                if (sts.idx_next_last)
                begin
                    ctl.occ_dec = 1'b1;
                    resp_next   = ST_DONE;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_MOVE_RD;
                end
            end

            S_DUMP_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rsel   = (sts.op == OP_DUMP_FWD) ? RSEL_IDX : RSEL_REV;
                state_next = S_DUMP_EMIT;
            end

            S_DUMP_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_ELEMENT;
                    ctl.emit_elem   = 1'b1;
                    ctl.emit_last   = sts.idx_last;
                    if (sts.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = resp_reg;
                    ctl.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.occ_inc |-> !sts.full)
        else $error("push while full");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken before the first finished");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> sts.out_free)
        else $error("emit while result register busy");

endmodule

// ===== design/deque_with_delete_by_value_top.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_top: bounded deque with delete by value
// Push, unknown command, empty remove and empty dump pass S_DECODE and S_RESP into
//   the result register; a remove scans (S_SCAN_RD/S_SCAN_CMP), then compacts
//   (S_MOVE_RD/S_MOVE_WR) element by element. A dump reads (S_DUMP_RD) and emits
//   (S_DUMP_EMIT) each element, waiting while the result register is busy.
// Throughput: one item at a time. Reset: rst_n clears pointers, sequencer and
//   result valid at once; the ring storage is not cleared.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_top #(
    parameter int CAPACITY = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    dwd_in_if.sink    req,
    dwd_out_if.source rsp
);
    import dwd_pkg::*;

    // controller <-> datapath bundles
    dwd_ctl_t ctl;
    dwd_sts_t sts;

    logic                     in_ready;
    logic                     out_valid;
    logic [STATUS_W-1:0]      out_status;
    logic signed [DATA_W-1:0] out_element;
    logic                     out_last;

    // Sequencer: takes an item only when idle, then walks the datapath through
    // the push, scan/compact or dump sequence for it.
    dwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // Datapath: ring storage, pointers and the result register. The result
    // register parts the two sides, so the next item can be taken while the
    // last result of the previous one still waits.
    dwd_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_cmd      (req.cmd),
        .in_value    (req.value),
        .out_valid   (out_valid),
        .out_status  (out_status),
        .out_element (out_element),
        .out_last    (out_last),
        .out_ready   (rsp.ready)
    );

    assign req.ready   = in_ready;
    assign rsp.valid   = out_valid;
    assign rsp.status  = out_status;
    assign rsp.element = out_element;
    assign rsp.last    = out_last;

endmodule
